// ----- src/ktk_pkg.sv -----
// Package for the keyed top-k sorted list core.
// Holds sizes, status and action codes, payload structs, FSM state type.
package ktk_pkg;
    localparam int MaxEntries = 16;
    localparam int IdxW = $clog2(MaxEntries);
    localparam int CntW = $clog2(MaxEntries + 1);

    typedef enum logic [1:0] {
        ACT_UPDATE = 2'd0,
        ACT_READ   = 2'd1,
        ACT_CLEAR  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_INSERTED   = 3'd0,
        ST_REPLACED   = 3'd1,
        ST_DROPPED    = 3'd2,
        ST_UPDATED    = 3'd3,
        ST_READ_OK    = 3'd4,
        ST_READ_EMPTY = 3'd5,
        ST_CLEARED    = 3'd6
    } t_status;

    typedef struct packed {
        logic [1:0]         action;
        logic [63:0]        key;
        logic signed [31:0] value;
        logic [3:0]         rank;
    } t_req;

    typedef struct packed {
        logic [2:0]         status;
        logic [3:0]         position;
        logic [63:0]        out_key;
        logic signed [31:0] out_value;
        logic [4:0]         count;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_REMOVE,
        S_INSERT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_step;
        logic rem_init;
        logic rem_step;
        logic ins_init;
        logic ins_step;
        logic clear;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_end;
        logic found;
        logic has_room;
        logic last_smaller;
        logic rem_end;
        logic ins_end;
        logic [1:0] action;
    } t_sts;
endpackage

// ----- src/keyed_top_k_sorted_list_core.sv -----
// Top level of the keyed top-k sorted list core.
// Requests: one at a time; the next is taken only after the result strobe.
// The key scan and the one-entry-per-cycle shift over the entry registers set how long each request takes.
// Reset (synchronous, active low) empties the list and sets capacity to 16.
// o_strobe marks each result for one cycle; the receiver cannot stall.
// Depends on ktk_pkg, ktk_ctrl, ktk_dp.
module keyed_top_k_sorted_list_core import ktk_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data,
    output logic       o_strobe,
    output t_rsp       o_rsp
);
    logic [4:0] r_top_size;
    t_cmd cmd;
    t_sts sts;
    logic ctrl_busy;
    logic start_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_top_size <= 5'd16;
        else if (i_cfg_we) r_top_size <= i_cfg_data;
    end

    assign start_ok = start && !busy;

    ktk_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start_ok),
        .i_sts(sts), .o_cmd(cmd), .o_busy(ctrl_busy)
    );

    ktk_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(i_req), .i_top_size(r_top_size),
        .i_cmd(cmd), .o_sts(sts), .o_valid(o_strobe), .o_rsp(o_rsp)
    );

    assign busy = ctrl_busy || o_strobe;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_rsp.count <= 5'(MaxEntries))
        else $error("count above capacity");
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.status == ST_CLEARED) |-> o_rsp.count == 5'd0)
        else $error("clear left entries");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result while idle");
endmodule

// ----- src/ktk_ctrl.sv -----
// Controller FSM for the keyed top-k core.
// Depends on ktk_pkg.
module ktk_ctrl import ktk_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_SEARCH;
            end
            S_SEARCH: begin
                if (i_sts.action != ACT_UPDATE || i_sts.scan_end || i_sts.found)
                    n_state = (i_sts.action == ACT_UPDATE) ? S_DECIDE : S_DONE;
            end
            S_DECIDE: begin
                if (i_sts.found) n_state = S_REMOVE;
                else if (i_sts.has_room) n_state = S_INSERT;
                else if (i_sts.last_smaller) n_state = S_REMOVE;
                else n_state = S_DONE;
            end
            S_REMOVE: begin
                if (i_sts.rem_end) n_state = S_INSERT;
            end
            S_INSERT: begin
                if (i_sts.ins_end) n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
            end
            S_SEARCH: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.action == ACT_CLEAR) o_cmd.clear = 1'b1;
            end
            S_DECIDE: begin
                o_cmd.rem_init = i_sts.found || (!i_sts.has_room && i_sts.last_smaller);
                o_cmd.ins_init = !i_sts.found && i_sts.has_room;
            end
            S_REMOVE: begin
                o_cmd.rem_step = 1'b1;
                o_cmd.ins_init = i_sts.rem_end;
            end
            S_INSERT: begin
                o_cmd.ins_step = 1'b1;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
            end
            default: ;
        endcase
    end
endmodule

// ----- src/ktk_dp.sv -----
// Datapath for the keyed top-k core: entry registers, scan, shift, result.
// Depends on ktk_pkg.
module ktk_dp import ktk_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_req       i_req,
    input  logic [4:0] i_top_size,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    output logic       o_valid,
    output t_rsp       o_rsp
);
    logic [63:0]        r_keys [MaxEntries];
    logic signed [31:0] r_vals [MaxEntries];
    logic [CntW-1:0]    r_count;
    t_req               r_req;
    logic [CntW-1:0]    r_idx;
    logic               r_found;
    logic [2:0]         r_status;
    logic               r_valid;
    t_rsp               r_rsp;

    logic [CntW-1:0] cap;
    logic [IdxW-1:0] idx;
    logic [IdxW-1:0] idx_m1;
    logic [IdxW-1:0] rank_i;
    logic            have;
    logic [IdxW-1:0] pos;

    assign idx    = r_idx[IdxW-1:0];
    assign idx_m1 = idx - 1'b1;
    assign rank_i = r_req.rank[IdxW-1:0];

    always_comb begin
        if (i_top_size < 5'd2) cap = CntW'(2);
        else if (i_top_size > 5'(MaxEntries)) cap = CntW'(MaxEntries);
        else cap = CntW'(i_top_size);
    end

    assign o_sts.scan_end     = (r_idx >= r_count);
    assign o_sts.found        = r_found;
    assign o_sts.has_room     = (r_count < cap);
    assign o_sts.last_smaller = (r_count != '0) &&
                                (r_vals[IdxW'(r_count - 1'b1)] < r_req.value);
    assign o_sts.rem_end      = (r_idx + 1'b1 >= r_count);
    assign o_sts.ins_end      = (r_idx == '0) || (r_vals[idx_m1] > r_req.value);
    assign o_sts.action       = r_req.action;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.ins_step && !o_sts.ins_end) begin
            r_keys[idx] <= r_keys[idx_m1];
            r_vals[idx] <= r_vals[idx_m1];
        end else if (i_cmd.ins_step) begin
            r_keys[idx] <= r_req.key;
            r_vals[idx] <= r_req.value;
        end
        if (i_cmd.rem_step && !o_sts.rem_end) begin
            r_keys[idx] <= r_keys[IdxW'(r_idx + 1'b1)];
            r_vals[idx] <= r_vals[IdxW'(r_idx + 1'b1)];
        end
        r_rsp.status    <= r_status;
        r_rsp.count     <= 5'(r_count);
        r_rsp.position  <= have ? 4'(pos) : ((r_req.action == ACT_READ) ? r_req.rank : 4'd0);
        r_rsp.out_key   <= have ? r_keys[pos] : 64'd0;
        r_rsp.out_value <= have ? r_vals[pos] : 32'sd0;
    end

    assign have = (r_status == ST_INSERTED) || (r_status == ST_REPLACED) ||
                  (r_status == ST_UPDATED) || (r_status == ST_READ_OK);
    assign pos  = (r_req.action == ACT_READ) ? rank_i : idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_idx    <= '0;
            r_found  <= 1'b0;
            r_status <= ST_DROPPED;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.load) begin
                r_idx    <= '0;
                r_found  <= 1'b0;
                r_status <= ST_DROPPED;
            end
            if (i_cmd.scan_step) begin
                unique case (r_req.action)
                    ACT_UPDATE: begin
                        if (!o_sts.scan_end && !r_found) begin
                            if (r_keys[idx] == r_req.key) r_found <= 1'b1;
                            else r_idx <= r_idx + 1'b1;
                        end
                    end
                    ACT_READ: begin
                        r_status <= (CntW'(r_req.rank) < r_count) ? ST_READ_OK
                                                                  : ST_READ_EMPTY;
                    end
                    ACT_CLEAR: begin
                        r_status <= ST_CLEARED;
                    end
                    default: r_status <= ST_DROPPED;
                endcase
            end
            if (i_cmd.clear) r_count <= '0;
            if (i_cmd.rem_init) begin
                if (r_found) begin
                    r_status <= ST_UPDATED;
                end else begin
                    r_status <= ST_REPLACED;
                    r_idx    <= r_count - 1'b1;
                end
            end
            if (i_cmd.rem_step) begin
                if (o_sts.rem_end) r_count <= r_count - 1'b1;
                else r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.ins_init) begin
                r_idx <= i_cmd.rem_step ? r_count - 1'b1 : r_count;
                if (!i_cmd.rem_step) r_status <= ST_INSERTED;
            end
            if (i_cmd.ins_step) begin
                if (o_sts.ins_end) r_count <= r_count + 1'b1;
                else r_idx <= r_idx - 1'b1;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;
endmodule
